FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked assertions with the usual reset qualifier.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock, inactive while in reset.
`define SDW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Overlapping implication, sampled on the rising clock, inactive while in reset.
`define SDW_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sdw_pkg.sv
// ----------------------------------------------------------------------------
// Sine displacement warp package
// Beat types, register indexes, fixed-point constants and the sine builder.
// ----------------------------------------------------------------------------
package sdw_pkg;

  localparam int unsigned PX_W       = 10;
  localparam int unsigned PY_W       = 9;
  localparam int unsigned COL_W      = 8;
  localparam int unsigned GAIN_W     = 10;
  localparam int unsigned PHASE_W    = 21;
  localparam int unsigned KSCALE_W   = 20;
  localparam int unsigned TURN_PROD_W = PHASE_W + KSCALE_W;
  localparam int unsigned SINE_W     = 15;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned RGB_W      = 3 * COL_W;
  localparam int unsigned OUT_FIFO_DEPTH = 16;

  // 0.001 / (2*pi) turns per phase unit, Q0.32.
  localparam logic [KSCALE_W-1:0] TURN_SCALE = 20'd683565;
  // 2*pi in Q2.30.
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  // One half in Q0.16.
  localparam logic [FRAC_W-1:0] S_HALF = 16'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_X = 1'b0,
    REG_GAIN_Y = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [PX_W-1:0]  pixel_x;
    logic [PY_W-1:0]  pixel_y;
    logic [COL_W-1:0] red_in;
    logic [COL_W-1:0] green_in;
    logic [COL_W-1:0] blue_in;
    logic             frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [COL_W-1:0] red_out;
    logic [COL_W-1:0] green_out;
    logic [COL_W-1:0] blue_out;
    logic             out_frame_start;
  } pix_out_t;

  typedef struct packed {
    pix_in_t pix;
    logic    wr_bank;
  } item_t;

  // Quarter-wave sine entry in Q0.15 from a truncated Q2.30 Taylor series.
  // Only ever evaluated at elaboration to fill a constant table.
  function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned j,
                                                     input int unsigned tb);
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] term;
    logic [63:0] prod;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] v;
    a    = (64'(j) * TWO_PI_Q30) >> tb;
    a2   = (a * a) >> 30;
    term = a;
    pos  = a;
    neg  = 64'd0;
    for (int k = 1; k <= 8; k++) begin
      prod = (term * a2) >> 30;
      unique case (k)
        1:       term = prod / 64'd6;
        2:       term = prod / 64'd20;
        3:       term = prod / 64'd42;
        4:       term = prod / 64'd72;
        5:       term = prod / 64'd110;
        6:       term = prod / 64'd156;
        7:       term = prod / 64'd210;
        default: term = prod / 64'd272;
      endcase
      if ((k % 2) == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    v = (pos > neg) ? pos - neg : 64'd0;
    v = (v * 64'd32768 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[SINE_W-1:0];
  endfunction

endpackage

FILE: rtl/sdw_stream_if.sv
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface sdw_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/sdw_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sdw_ram #(
  parameter int unsigned DATA_W = 24,
  parameter int unsigned DEPTH  = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/sdw_phase.sv
// ----------------------------------------------------------------------------
// Phase stages
// Gain products, phase sum and scaling to turns; yields the sine table index.
// ----------------------------------------------------------------------------
module sdw_phase #(
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  sdw_pkg::item_t                    item_i,
  input  logic [sdw_pkg::GAIN_W-1:0]        gain_x_i,
  input  logic [sdw_pkg::GAIN_W-1:0]        gain_y_i,
  output logic                              valid_o,
  output sdw_pkg::item_t                    item_o,
  output logic [SINE_TABLE_BITS-1:0]        idx_o
);

  localparam int unsigned PA_W = sdw_pkg::PX_W + sdw_pkg::GAIN_W;
  localparam int unsigned PB_W = sdw_pkg::PY_W + sdw_pkg::GAIN_W;
  localparam int unsigned PW   = sdw_pkg::PHASE_W;
  localparam int unsigned TW   = sdw_pkg::TURN_PROD_W;

  logic                       v1_q, v2_q, v3_q;
  sdw_pkg::item_t             item1_q, item2_q, item3_q;
  logic [PA_W-1:0]            pa_d, pa_q;
  logic [PB_W-1:0]            pb_d, pb_q;
  logic [PW-1:0]              p_d, p_q;
  logic [TW-1:0]              turn_prod;
  logic [SINE_TABLE_BITS-1:0] idx_d, idx_q;

  assign pa_d      = PA_W'(item_i.pix.pixel_x) * PA_W'(gain_x_i);
  assign pb_d      = PB_W'(item_i.pix.pixel_y) * PB_W'(gain_y_i);
  assign p_d       = PW'(pa_q) + PW'(pb_q);
  assign turn_prod = TW'(p_q) * TW'(sdw_pkg::TURN_SCALE);
  assign idx_d     = turn_prod[31 -: SINE_TABLE_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    item1_q <= item_i;
    pa_q    <= pa_d;
    pb_q    <= pb_d;
    item2_q <= item1_q;
    p_q     <= p_d;
    item3_q <= item2_q;
    idx_q   <= idx_d;
  end

  assign valid_o = v3_q;
  assign item_o  = item3_q;
  assign idx_o   = idx_q;

endmodule

FILE: rtl/sdw_sine.sv
// ----------------------------------------------------------------------------
// Sine stages
// Quarter-wave table lookup, offset fraction s and the column/row offsets.
// ----------------------------------------------------------------------------
module sdw_sine #(
  parameter int unsigned WIDTH           = 640,
  parameter int unsigned HEIGHT          = 480,
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  sdw_pkg::item_t                    item_i,
  input  logic [SINE_TABLE_BITS-1:0]        idx_i,
  output logic                              valid_o,
  output sdw_pkg::item_t                    item_o,
  output logic [$clog2(WIDTH)-1:0]          off_x_o,
  output logic [$clog2(HEIGHT)-1:0]         off_y_o
);

  localparam int unsigned TB     = SINE_TABLE_BITS;
  localparam int unsigned QDEPTH = (1 << (TB - 2)) + 1;
  localparam int unsigned JW     = TB - 1;
  localparam int unsigned SW     = sdw_pkg::SINE_W;
  localparam int unsigned FW     = sdw_pkg::FRAC_W;
  localparam int unsigned CW     = $clog2(WIDTH);
  localparam int unsigned RW     = $clog2(HEIGHT);
  localparam int unsigned WB     = $clog2(WIDTH + 1);
  localparam int unsigned HB     = $clog2(HEIGHT + 1);
  localparam logic [TB-1:0] QUARTER = {2'b01, {(TB - 2){1'b0}}};
  localparam logic [TB-1:0] HALF    = {1'b1, {(TB - 1){1'b0}}};
  localparam logic [WB-1:0] W_K     = WB'(WIDTH);
  localparam logic [HB-1:0] H_K     = HB'(HEIGHT);

  typedef logic [QDEPTH-1:0][SW-1:0] qtab_t;

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int j = 0; j < QDEPTH; j++) begin
      t[j] = sdw_pkg::quarter_sine(j, TB);
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  logic              v4_q, v5_q, v6_q;
  sdw_pkg::item_t    item4_q, item5_q, item6_q;
  logic [TB-1:0]     j_ext;
  logic [TB-1:0]     j_fold;
  logic [JW-1:0]     j_idx;
  logic [SW-1:0]     mag_d, mag_q;
  logic              neg_q;
  logic [FW-1:0]     s_d, s_q;
  logic [WB+FW-1:0]  prod_x;
  logic [HB+FW-1:0]  prod_y;
  logic [CW-1:0]     off_x_d, off_x_q;
  logic [RW-1:0]     off_y_d, off_y_q;

  assign j_ext  = {1'b0, idx_i[TB-2:0]};
  assign j_fold = (j_ext > QUARTER) ? HALF - j_ext : j_ext;
  assign j_idx  = j_fold[JW-1:0];
  assign mag_d  = QTAB[j_idx];

  assign s_d = neg_q ? sdw_pkg::S_HALF - FW'(mag_q) : sdw_pkg::S_HALF + FW'(mag_q);

  assign prod_x  = (WB + FW)'(W_K) * (WB + FW)'(s_q);
  assign prod_y  = (HB + FW)'(H_K) * (HB + FW)'(s_q);
  assign off_x_d = prod_x[FW +: CW];
  assign off_y_d = prod_y[FW +: RW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v4_q <= valid_i;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    item4_q <= item_i;
    mag_q   <= mag_d;
    neg_q   <= idx_i[TB-1];
    item5_q <= item4_q;
    s_q     <= s_d;
    item6_q <= item5_q;
    off_x_q <= off_x_d;
    off_y_q <= off_y_d;
  end

  assign valid_o = v6_q;
  assign item_o  = item6_q;
  assign off_x_o = off_x_q;
  assign off_y_o = off_y_q;

endmodule

FILE: rtl/sdw_addr.sv
// ----------------------------------------------------------------------------
// Address stages
// Wraps the displaced coordinates into the frame and forms the bank addresses.
// ----------------------------------------------------------------------------
module sdw_addr #(
  parameter int unsigned WIDTH  = 640,
  parameter int unsigned HEIGHT = 480
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  sdw_pkg::item_t                      item_i,
  input  logic [$clog2(WIDTH)-1:0]            off_x_i,
  input  logic [$clog2(HEIGHT)-1:0]           off_y_i,
  output logic                                valid_o,
  output sdw_pkg::item_t                      item_o,
  output logic                                we_o,
  output logic [$clog2(WIDTH*HEIGHT)-1:0]     waddr_o,
  output logic [$clog2(WIDTH*HEIGHT)-1:0]     raddr_o
);

  localparam int unsigned CW = $clog2(WIDTH);
  localparam int unsigned RW = $clog2(HEIGHT);
  localparam int unsigned AW = $clog2(WIDTH * HEIGHT);
  localparam int unsigned XS = ((sdw_pkg::PX_W > CW) ? sdw_pkg::PX_W : CW) + 1;
  localparam int unsigned YS = ((sdw_pkg::PY_W > RW) ? sdw_pkg::PY_W : RW) + 1;
  localparam logic [XS-1:0] W_C = XS'(WIDTH);
  localparam logic [YS-1:0] H_C = YS'(HEIGHT);
  localparam logic [CW-1:0] W_LAST = CW'(WIDTH - 1);
  localparam logic [RW-1:0] H_LAST = RW'(HEIGHT - 1);

  logic              v7_q, v8_q, v9_q;
  sdw_pkg::item_t    item7_q, item8_q, item9_q;
  logic [XS-1:0]     sx_d, sx_q, tx;
  logic [YS-1:0]     sy_d, sy_q, ty;
  logic [CW-1:0]     rx_d, rx_q;
  logic [RW-1:0]     ry_d, ry_q;
  logic [XS-1:0]     px8;
  logic [YS-1:0]     py8;
  logic              we_d, we_q;
  logic [AW-1:0]     waddr_d, waddr_q;
  logic [AW-1:0]     raddr_d, raddr_q;

  assign sx_d = XS'(item_i.pix.pixel_x) + XS'(off_x_i);
  assign sy_d = YS'(item_i.pix.pixel_y) + YS'(off_y_i);

  assign tx   = (sx_q >= W_C) ? sx_q - W_C : sx_q;
  assign ty   = (sy_q >= H_C) ? sy_q - H_C : sy_q;
  assign rx_d = (tx >= W_C) ? W_LAST : tx[CW-1:0];
  assign ry_d = (ty >= H_C) ? H_LAST : ty[RW-1:0];

  assign px8     = XS'(item8_q.pix.pixel_x);
  assign py8     = YS'(item8_q.pix.pixel_y);
  assign we_d    = v8_q && (px8 < W_C) && (py8 < H_C);
  assign waddr_d = AW'(py8[RW-1:0]) * AW'(WIDTH) + AW'(px8[CW-1:0]);
  assign raddr_d = AW'(ry_q) * AW'(WIDTH) + AW'(rx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
      we_q <= 1'b0;
    end else begin
      v7_q <= valid_i;
      v8_q <= v7_q;
      v9_q <= v8_q;
      we_q <= we_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item7_q <= item_i;
    sx_q    <= sx_d;
    sy_q    <= sy_d;
    item8_q <= item7_q;
    rx_q    <= rx_d;
    ry_q    <= ry_d;
    item9_q <= item8_q;
    waddr_q <= waddr_d;
    raddr_q <= raddr_d;
  end

  assign valid_o = v9_q;
  assign item_o  = item9_q;
  assign we_o    = we_q;
  assign waddr_o = waddr_q;
  assign raddr_o = raddr_q;

endmodule

FILE: rtl/sine_displacement_pixel_warp.sv
// ----------------------------------------------------------------------------
// Sine displacement pixel warp
// Each accepted pixel beat is written into the current frame bank, and one
// result beat carries the colour of the previous frame read from the other
// bank at a sine-displaced location; frame_start swaps the banks. A new pixel
// is taken in every clock cycle while pix_i.ready is high, limited by the one
// write port and one read port of each bank; its result passes the phase, sine
// and address stages and the bank read before it enters the output queue.
// A sixteen-beat output queue keeps input flowing while the sink stalls; but
// for the bank clear, input is held off only when sixteen results are in flight
// or waiting. After reset both banks are cleared to zero, one word per cycle;
// no pixel is taken meanwhile, while gain writes are taken as ever.
// ----------------------------------------------------------------------------
module sine_displacement_pixel_warp #(
  parameter int unsigned WIDTH           = 640,
  parameter int unsigned HEIGHT          = 480,
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sdw_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sdw_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  sdw_stream_if.sink                         pix_i,
  sdw_stream_if.source                       pix_o
);

  localparam int unsigned PIXELS = WIDTH * HEIGHT;
  localparam int unsigned AW     = $clog2(PIXELS);
  localparam int unsigned CW     = $clog2(WIDTH);
  localparam int unsigned RW     = $clog2(HEIGHT);
  localparam int unsigned FDEPTH = sdw_pkg::OUT_FIFO_DEPTH;
  localparam int unsigned PTR_W  = $clog2(FDEPTH) + 1;
  localparam int unsigned OCC_W  = $clog2(FDEPTH + 1);
  localparam int unsigned DW     = sdw_pkg::RGB_W;
  localparam logic [AW-1:0] CLR_LAST = AW'(PIXELS - 1);

  logic [sdw_pkg::GAIN_W-1:0] gain_x_q, gain_y_q;
  logic                       bank_sel_q;
  logic                       clr_busy_q;
  logic [AW-1:0]              clr_cnt_q;
  logic [OCC_W-1:0]           occ_d, occ_q;
  logic                       accept, pop;
  sdw_pkg::item_t             item_in;

  logic                       ph_valid;
  sdw_pkg::item_t             ph_item;
  logic [SINE_TABLE_BITS-1:0] ph_idx;
  logic                       sn_valid;
  sdw_pkg::item_t             sn_item;
  logic [CW-1:0]              sn_off_x;
  logic [RW-1:0]              sn_off_y;
  logic                       ad_valid;
  sdw_pkg::item_t             ad_item;
  logic                       ad_we;
  logic [AW-1:0]              ad_waddr, ad_raddr;

  logic                       we_a, we_b;
  logic [AW-1:0]              bank_waddr;
  logic [DW-1:0]              bank_wdata;
  logic [DW-1:0]              rdata_a, rdata_b, rdata;
  logic                       v10_q;
  logic                       wr_bank10_q;
  logic                       fs10_q;

  sdw_pkg::pix_out_t          fifo_q [FDEPTH];
  sdw_pkg::pix_out_t          push_beat;
  logic [PTR_W-1:0]           wr_ptr_q, rd_ptr_q;

  assign accept = pix_i.valid && pix_i.ready;
  assign pop    = pix_o.valid && pix_o.ready;

  assign pix_i.ready = !clr_busy_q && (occ_q < OCC_W'(FDEPTH));

  assign item_in.pix     = pix_i.payload;
  assign item_in.wr_bank = bank_sel_q ^ pix_i.payload.frame_start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_x_q <= '0;
      gain_y_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sdw_pkg::REG_GAIN_X: gain_x_q <= cfg_wdata_i;
        sdw_pkg::REG_GAIN_Y: gain_y_q <= cfg_wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_sel_q <= 1'b0;
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
      occ_q      <= '0;
    end else begin
      if (accept) begin
        bank_sel_q <= item_in.wr_bank;
      end
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
        if (clr_cnt_q == CLR_LAST) begin
          clr_busy_q <= 1'b0;
        end
      end
      occ_q <= occ_d;
    end
  end

  always_comb begin
    occ_d = occ_q;
    if (accept && !pop) begin
      occ_d = occ_q + OCC_W'(1);
    end else if (pop && !accept) begin
      occ_d = occ_q - OCC_W'(1);
    end
  end

  sdw_phase #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_phase (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (accept),
    .item_i   (item_in),
    .gain_x_i (gain_x_q),
    .gain_y_i (gain_y_q),
    .valid_o  (ph_valid),
    .item_o   (ph_item),
    .idx_o    (ph_idx)
  );

  sdw_sine #(
    .WIDTH           (WIDTH),
    .HEIGHT          (HEIGHT),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_sine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ph_valid),
    .item_i  (ph_item),
    .idx_i   (ph_idx),
    .valid_o (sn_valid),
    .item_o  (sn_item),
    .off_x_o (sn_off_x),
    .off_y_o (sn_off_y)
  );

  sdw_addr #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_addr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sn_valid),
    .item_i  (sn_item),
    .off_x_i (sn_off_x),
    .off_y_i (sn_off_y),
    .valid_o (ad_valid),
    .item_o  (ad_item),
    .we_o    (ad_we),
    .waddr_o (ad_waddr),
    .raddr_o (ad_raddr)
  );

  // Bank a is written when wr_bank is low and its read data is used when it is high.
  assign we_a       = clr_busy_q || (ad_we && !ad_item.wr_bank);
  assign we_b       = clr_busy_q || (ad_we && ad_item.wr_bank);
  assign bank_waddr = clr_busy_q ? clr_cnt_q : ad_waddr;
  assign bank_wdata = clr_busy_q ? '0 :
                      {ad_item.pix.red_in, ad_item.pix.green_in, ad_item.pix.blue_in};

  sdw_ram #(
    .DATA_W (DW),
    .DEPTH  (PIXELS)
  ) u_bank_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (bank_waddr),
    .wdata_i (bank_wdata),
    .re_i    (ad_valid),
    .raddr_i (ad_raddr),
    .rdata_o (rdata_a)
  );

  sdw_ram #(
    .DATA_W (DW),
    .DEPTH  (PIXELS)
  ) u_bank_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (bank_waddr),
    .wdata_i (bank_wdata),
    .re_i    (ad_valid),
    .raddr_i (ad_raddr),
    .rdata_o (rdata_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v10_q <= 1'b0;
    end else begin
      v10_q <= ad_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_bank10_q <= ad_item.wr_bank;
    fs10_q      <= ad_item.pix.frame_start;
  end

  assign rdata = wr_bank10_q ? rdata_a : rdata_b;

  assign push_beat.red_out         = rdata[2*sdw_pkg::COL_W +: sdw_pkg::COL_W];
  assign push_beat.green_out       = rdata[sdw_pkg::COL_W +: sdw_pkg::COL_W];
  assign push_beat.blue_out        = rdata[0 +: sdw_pkg::COL_W];
  assign push_beat.out_frame_start = fs10_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      if (v10_q) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v10_q) begin
      fifo_q[wr_ptr_q[PTR_W-2:0]] <= push_beat;
    end
  end

  assign pix_o.valid   = (wr_ptr_q != rd_ptr_q);
  assign pix_o.payload = fifo_q[rd_ptr_q[PTR_W-2:0]];

endmodule

FILE: rtl/sdw_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Watches the pixel channels of the warp block over time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sdw_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input sdw_pkg::pix_out_t out_payload_i
);

  localparam int unsigned LATENCY = 11;
  localparam int unsigned CNT_W   = 6;

  logic             in_fire, out_fire;
  logic [CNT_W-1:0] pending_q;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + CNT_W'(in_fire) - CNT_W'(out_fire);
    end
  end

  // A waiting result beat stays put until it is taken.
  `SDW_ASSERT(a_out_hold, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_payload_i)), "result beat changed while stalled")

  // The banks are being cleared straight after reset, so no pixel is taken.
  `SDW_ASSERT_IMPL(a_clear_blocks, $rose(rst_ni), !in_ready_i, "pixel taken during bank clear")

  // A result queue that was empty only fills from an earlier pixel that has passed the whole pipeline.
  `SDW_ASSERT_IMPL(a_latency, $rose(out_valid_i), $past(in_fire, LATENCY), "result without matching pixel")

  // Every result beat answers a pixel beat that has not yet been answered.
  `SDW_ASSERT_IMPL(a_no_extra, out_fire, pending_q != '0, "more results than pixels")

endmodule

bind sine_displacement_pixel_warp sdw_checker u_sdw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (pix_i.valid),
  .in_ready_i    (pix_i.ready),
  .out_valid_i   (pix_o.valid),
  .out_ready_i   (pix_o.ready),
  .out_payload_i (pix_o.payload)
);
